### rtl/sspi_pkg.sv
package sspi_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned MODE_W    = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OP_W      = 4;

  // Operating modes
  localparam logic [MODE_W-1:0] MODE_START = 7'd0;
  localparam logic [MODE_W-1:0] MODE_ZERO  = 7'd1;
  localparam logic [MODE_W-1:0] MODE_WAIT  = 7'd2;
  localparam logic [MODE_W-1:0] MODE_PI    = 7'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IQ_LIMIT   = 2'd3;

  localparam logic [CFG_W-1:0] BASE_SPEED_RST = 31'd65536000;
  localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 31'd0;
  localparam logic [CFG_W-1:0] INTEG_GAIN_RST = 31'd0;
  localparam logic [CFG_W-1:0] IQ_LIMIT_RST   = 31'd65536;

  // pi/30 and 30 rpm in Q16.16
  localparam logic signed [DATA_W-1:0] PI_OVER_30_Q16 = 32'sd6863;
  localparam logic signed [DATA_W-1:0] START_REF_Q16  = 32'sd1966080;

  // Datapath operations
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_NONE    = 4'd0;
  localparam op_t OP_STOP    = 4'd1;
  localparam op_t OP_START   = 4'd2;
  localparam op_t OP_ZERO    = 4'd3;
  localparam op_t OP_HANDOFF = 4'd4;
  localparam op_t OP_NOACT   = 4'd5;
  localparam op_t OP_MUL_W   = 4'd6;
  localparam op_t OP_ERR     = 4'd7;
  localparam op_t OP_MUL_I   = 4'd8;
  localparam op_t OP_ACC     = 4'd9;
  localparam op_t OP_MUL_P   = 4'd10;
  localparam op_t OP_FINAL   = 4'd11;
  localparam op_t OP_PUBLISH = 4'd12;

  typedef struct packed {
    logic                     run;
    logic                     mode_write;
    logic [MODE_W-1:0]        mode_value;
    logic signed [DATA_W-1:0] speed_ref_rpm;
    logic signed [DATA_W-1:0] speed_est_rpm;
    logic signed [DATA_W-1:0] speed_est_rad;
    logic signed [DATA_W-1:0] iq_present;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode_now;
    logic signed [DATA_W-1:0] speed_ref_out;
    logic                     speed_ref_forced;
    logic                     handoff;
    logic signed [DATA_W-1:0] iq_ref;
    logic                     iq_ref_valid;
    logic                     id_ref_clear;
  } out_item_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic              run;
    logic [MODE_W-1:0] mode;
    logic              above_base;
  } status_t;

  // Symmetric clamp of a wide sum to +-lim, result fits 32 bits
  function automatic logic signed [DATA_W-1:0] clamp48(input logic signed [47:0] v,
                                                       input logic [CFG_W-1:0] lim);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    logic signed [47:0] r;
    hi = $signed({17'b0, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

endpackage

### rtl/sspi_datapath.sv
module sspi_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  sspi_pkg::in_item_t              in_data,
  input  logic                            cfg_valid,
  input  logic [sspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspi_pkg::DATA_W-1:0]     cfg_data,
  input  sspi_pkg::cmd_t                  cmd,
  output sspi_pkg::status_t               status,
  output sspi_pkg::out_item_t             out_data
);

  sspi_pkg::in_item_t                in_r;
  sspi_pkg::out_item_t               res;
  sspi_pkg::out_item_t               res_next;
  sspi_pkg::out_item_t               out_r;
  logic [sspi_pkg::MODE_W-1:0]       mode;
  logic signed [31:0]                integ;
  logic [sspi_pkg::CFG_W-1:0]        base_speed;
  logic [sspi_pkg::CFG_W-1:0]        prop_gain;
  logic [sspi_pkg::CFG_W-1:0]        integ_gain;
  logic [sspi_pkg::CFG_W-1:0]        iq_limit;

  logic signed [63:0]                prod;
  logic signed [63:0]                prod_next;
  logic signed [31:0]                err;
  logic signed [31:0]                err_next;
  logic signed [31:0]                acc;
  logic signed [31:0]                acc_next;
  logic signed [31:0]                iq_next;
  logic signed [31:0]                mul_a;
  logic signed [31:0]                mul_b;
  logic signed [31:0]                w;
  logic signed [32:0]                diff;
  logic signed [47:0]                prod_sh;
  logic signed [47:0]                acc_sum;
  logic signed [47:0]                fin_sum;

  // Shared multiplier operand selection
  always_comb begin
    case (cmd.op)
      sspi_pkg::OP_MUL_W: begin
        mul_a = in_r.speed_ref_rpm;
        mul_b = sspi_pkg::PI_OVER_30_Q16;
      end
      sspi_pkg::OP_MUL_I: begin
        mul_a = err;
        mul_b = $signed({1'b0, integ_gain});
      end
      default: begin
        mul_a = err;
        mul_b = $signed({1'b0, prop_gain});
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Floor shift by 16 is a plain bit slice of the product
  assign prod_sh = prod[63:16];
  assign w       = prod[47:16];
  assign diff    = {w[31], w} - {in_r.speed_est_rad[31], in_r.speed_est_rad};

  always_comb begin
    if (diff > 33'sh0_7FFF_FFFF) begin
      err_next = 32'sh7FFF_FFFF;
    end else if (diff < -33'sh0_8000_0000) begin
      err_next = -32'sh8000_0000;
    end else begin
      err_next = diff[31:0];
    end
  end

  assign acc_sum  = prod_sh + {{16{integ[31]}}, integ};
  assign acc_next = sspi_pkg::clamp48(acc_sum, iq_limit);
  assign fin_sum  = prod_sh + {{16{acc[31]}}, acc};
  assign iq_next  = sspi_pkg::clamp48(fin_sum, iq_limit);

  assign status.run        = in_r.run;
  assign status.mode       = mode;
  assign status.above_base = $signed({in_r.speed_est_rpm[31], in_r.speed_est_rpm})
                             > $signed({2'b00, base_speed});

  // Result item for the operation in hand
  always_comb begin
    res_next          = '0;
    res_next.mode_now = mode;
    case (cmd.op)
      sspi_pkg::OP_STOP: begin
        res_next.iq_ref_valid = 1'b1;
        res_next.id_ref_clear = 1'b1;
      end
      sspi_pkg::OP_START: begin
        res_next.speed_ref_out    = sspi_pkg::START_REF_Q16;
        res_next.speed_ref_forced = 1'b1;
      end
      sspi_pkg::OP_ZERO: begin
        res_next.speed_ref_forced = 1'b1;
      end
      sspi_pkg::OP_HANDOFF: begin
        res_next.mode_now         = sspi_pkg::MODE_PI;
        res_next.speed_ref_out    = $signed({1'b0, base_speed});
        res_next.speed_ref_forced = 1'b1;
        res_next.handoff          = 1'b1;
      end
      sspi_pkg::OP_FINAL: begin
        res_next.iq_ref       = iq_next;
        res_next.iq_ref_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_speed <= sspi_pkg::BASE_SPEED_RST;
      prop_gain  <= sspi_pkg::PROP_GAIN_RST;
      integ_gain <= sspi_pkg::INTEG_GAIN_RST;
      iq_limit   <= sspi_pkg::IQ_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        sspi_pkg::REG_BASE_SPEED: base_speed <= cfg_data[sspi_pkg::CFG_W-1:0];
        sspi_pkg::REG_PROP_GAIN:  prop_gain  <= cfg_data[sspi_pkg::CFG_W-1:0];
        sspi_pkg::REG_INTEG_GAIN: integ_gain <= cfg_data[sspi_pkg::CFG_W-1:0];
        sspi_pkg::REG_IQ_LIMIT:   iq_limit   <= cfg_data[sspi_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state held across items
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= sspi_pkg::MODE_START;
      integ <= '0;
    end else begin
      if (cmd.load && in_data.mode_write) begin
        mode <= in_data.mode_value;
      end
      if (cmd.op == sspi_pkg::OP_HANDOFF) begin
        mode  <= sspi_pkg::MODE_PI;
        integ <= in_r.iq_present;
      end else if (cmd.op == sspi_pkg::OP_ACC) begin
        integ <= acc_next;
      end
    end
  end

  // Working registers and the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    case (cmd.op)
      sspi_pkg::OP_MUL_W, sspi_pkg::OP_MUL_I, sspi_pkg::OP_MUL_P: prod <= prod_next;
      sspi_pkg::OP_ERR:   err <= err_next;
      sspi_pkg::OP_ACC:   acc <= acc_next;
      sspi_pkg::OP_STOP, sspi_pkg::OP_START, sspi_pkg::OP_ZERO,
      sspi_pkg::OP_HANDOFF, sspi_pkg::OP_NOACT, sspi_pkg::OP_FINAL: res <= res_next;
      sspi_pkg::OP_PUBLISH: out_r <= res;
      default: ;
    endcase
  end

  assign out_data = out_r;

endmodule

### rtl/sspi_ctrl.sv
module sspi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sspi_pkg::status_t status,
  output sspi_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_ERR    = 4'd2;
  localparam logic [3:0] S_MUL_I  = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_MUL_P  = 4'd5;
  localparam logic [3:0] S_FINAL  = 4'd6;
  localparam logic [3:0] S_PUB    = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_full;
  logic       out_full_next;
  logic       publish;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_full;
  assign publish   = (state == S_PUB) && (!out_full || out_ready);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = sspi_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_PUB;
        if (!status.run) begin
          cmd.op = sspi_pkg::OP_STOP;
        end else if (status.mode == sspi_pkg::MODE_START) begin
          cmd.op = sspi_pkg::OP_START;
        end else if (status.mode == sspi_pkg::MODE_ZERO) begin
          cmd.op = sspi_pkg::OP_ZERO;
        end else if (status.mode == sspi_pkg::MODE_WAIT && status.above_base) begin
          cmd.op = sspi_pkg::OP_HANDOFF;
        end else if (status.mode == sspi_pkg::MODE_PI) begin
          cmd.op     = sspi_pkg::OP_MUL_W;
          state_next = S_ERR;
        end else begin
          cmd.op = sspi_pkg::OP_NOACT;
        end
      end
      S_ERR: begin
        cmd.op     = sspi_pkg::OP_ERR;
        state_next = S_MUL_I;
      end
      S_MUL_I: begin
        cmd.op     = sspi_pkg::OP_MUL_I;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = sspi_pkg::OP_ACC;
        state_next = S_MUL_P;
      end
      S_MUL_P: begin
        cmd.op     = sspi_pkg::OP_MUL_P;
        state_next = S_FINAL;
      end
      S_FINAL: begin
        cmd.op     = sspi_pkg::OP_FINAL;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (publish) begin
          cmd.op     = sspi_pkg::OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (publish) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == sspi_pkg::OP_PUBLISH) |-> (!out_full || out_ready))
    else $error("result register overwritten");

  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECIDE))
    else $error("accepted item not decoded");

  a_full_from_pub: assert property (@(posedge clk) disable iff (rst)
    $rose(out_full) |-> $past(state == S_PUB))
    else $error("result shown without publish");

  a_final_pub: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) |=> (state == S_PUB))
    else $error("PI result not published");

endmodule

### rtl/sensorless_speed_pi_controller_top.sv
// Speed PI controller with start-up mode sequencing and anti-windup clamp.
// One item is one control tick; one result item comes back for each. In
// PI mode (mode 4) the three chained products (reference scaling, integral
// and proportional terms) go one after another through a single registered
// 32x32 multiplier. All other cases go from the decision straight to the
// publish step. A finished result sits in an output register, so the next
// item is taken while it waits. Configuration writes are taken at any time
// and should be made while idle.
module sensorless_speed_pi_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  sspi_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sspi_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sspi_pkg::DATA_W-1:0]     cfg_data
);

  sspi_pkg::cmd_t    cmd;
  sspi_pkg::status_t status;

  assign cfg_ready = 1'b1;

  sspi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sspi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### verif/tb_sensorless_speed_pi_controller_top.sv
`timescale 1ns / 100ps

module tb_sensorless_speed_pi_controller_top;
  import sspi_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IDLE = 7'd99;
  localparam int unsigned RPM_SPAN = 3000 * 65536;
  localparam int unsigned RAD_SPAN = 320 * 65536;
  localparam int unsigned IQ_SPAN  = 64 * 65536;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_TICKS = 191;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t  tick;
    bit        typed;
    out_item_t res;
  } row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  // predictor state and register copies
  logic [CFG_W-1:0]  cfg_base = BASE_SPEED_RST;
  logic [CFG_W-1:0]  cfg_kp   = PROP_GAIN_RST;
  logic [CFG_W-1:0]  cfg_ki   = INTEG_GAIN_RST;
  logic [CFG_W-1:0]  cfg_lim  = IQ_LIMIT_RST;
  logic [MODE_W-1:0] ctl_mode = MODE_START;
  int                integ_st = 0;

  out_item_t due_results[$];
  row_t      rows[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        cycles = 0;

  sensorless_speed_pi_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sensorless_speed_pi_controller_top regression: fail");
      $finish;
    end
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // one control step; updates mode and integrator
  function automatic out_item_t predict_ctl_step(in_item_t t);
    out_item_t o;
    longint    lim, w, err, acc;
    o = '0;
    if (t.mode_write) ctl_mode = t.mode_value;
    if (!t.run) begin
      o.iq_ref_valid = 1'b1;
      o.id_ref_clear = 1'b1;
    end else begin
      case (ctl_mode)
        MODE_START: begin
          o.speed_ref_out    = START_REF_Q16;
          o.speed_ref_forced = 1'b1;
        end
        MODE_ZERO: o.speed_ref_forced = 1'b1;
        MODE_WAIT: begin
          if (longint'($signed(t.speed_est_rpm)) > longint'(cfg_base)) begin
            o.speed_ref_out    = {1'b0, cfg_base};
            o.speed_ref_forced = 1'b1;
            o.handoff          = 1'b1;
            ctl_mode           = MODE_PI;
            integ_st           = $signed(t.iq_present);
          end
        end
        MODE_PI: begin
          lim = longint'(cfg_lim);
          w   = (longint'($signed(t.speed_ref_rpm)) * longint'(PI_OVER_30_Q16)) >>> 16;
          err = w - longint'($signed(t.speed_est_rad));
          if (err > 64'sd2147483647) err = 64'sd2147483647;
          if (err < -64'sd2147483648) err = -64'sd2147483648;
          acc = longint'(integ_st) + ((err * longint'(cfg_ki)) >>> 16);
          acc = clamp_sym(acc, lim);
          integ_st = int'(acc);
          o.iq_ref       = 32'(clamp_sym(((err * longint'(cfg_kp)) >>> 16) + acc, lim));
          o.iq_ref_valid = 1'b1;
        end
        default: ;
      endcase
    end
    o.mode_now = ctl_mode;
    return o;
  endfunction

  function automatic logic [DATA_W-1:0] pick_q16(int unsigned span);
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      default: return 32'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    endcase
  endfunction

  function automatic in_item_t make_tick();
    in_item_t          t;
    logic [MODE_W-1:0] m;
    longint            b;
    t.run        = ($urandom_range(99) >= 6);
    t.mode_write = ($urandom_range(99) < 12);
    t.mode_value = 7'($urandom_range(127));
    if (t.mode_write) begin
      case ($urandom_range(7))
        0: t.mode_value = MODE_START;
        1: t.mode_value = MODE_ZERO;
        2, 3: t.mode_value = MODE_WAIT;
        4: t.mode_value = MODE_PI;
        5: t.mode_value = MODE_IDLE;
        default: ;
      endcase
    end
    m = t.mode_write ? t.mode_value : ctl_mode;
    t.speed_ref_rpm = pick_q16(RPM_SPAN);
    t.speed_est_rad = pick_q16(RAD_SPAN);
    t.iq_present    = pick_q16(IQ_SPAN);
    // while waiting, keep the estimate near the base speed so handoff comes soon
    if (m == MODE_WAIT && $urandom_range(3) != 0) begin
      b = longint'(cfg_base) - 196608;
      b = b + longint'(int'($urandom_range(0, 262144)));
      if (b > 64'sd2147483647) b = 64'sd2147483647;
      t.speed_est_rpm = b[31:0];
    end else begin
      t.speed_est_rpm = pick_q16(RPM_SPAN);
    end
    return t;
  endfunction

  function automatic in_item_t mk_tick(logic run, logic mw, logic [MODE_W-1:0] mv,
                                       logic [31:0] sref, logic [31:0] erpm,
                                       logic [31:0] erad, logic [31:0] iq);
    in_item_t t;
    t.run           = run;
    t.mode_write    = mw;
    t.mode_value    = mv;
    t.speed_ref_rpm = sref;
    t.speed_est_rpm = erpm;
    t.speed_est_rad = erad;
    t.iq_present    = iq;
    return t;
  endfunction

  function automatic out_item_t mk_res(logic [MODE_W-1:0] mode, logic [31:0] sref,
                                       logic forced, logic hand, logic [31:0] iq,
                                       logic iqv, logic idc);
    out_item_t o;
    o.mode_now         = mode;
    o.speed_ref_out    = sref;
    o.speed_ref_forced = forced;
    o.handoff          = hand;
    o.iq_ref           = iq;
    o.iq_ref_valid     = iqv;
    o.id_ref_clear     = idc;
    return o;
  endfunction

  task automatic add_row(in_item_t t, bit typed, out_item_t r);
    row_t row;
    row.tick  = t;
    row.typed = typed;
    row.res   = r;
    rows.push_back(row);
  endtask

  task automatic build_rows();
    out_item_t stopped, none;
    stopped = '0;
    none    = '0;
    add_row(mk_tick(0, 0, MODE_START, 0, 0, 0, 0), 1,
            mk_res(MODE_START, 0, 0, 0, 0, 1, 1));
    add_row(mk_tick(1, 0, MODE_START, 0, 0, 0, 0), 1,
            mk_res(MODE_START, START_REF_Q16, 1, 0, 0, 0, 0));
    add_row(mk_tick(1, 1, MODE_ZERO, '1, '1, '1, '1), 1,
            mk_res(MODE_ZERO, 0, 1, 0, 0, 0, 0));
    // mode write while stopped still lands
    add_row(mk_tick(0, 1, MODE_WAIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000), 1, mk_res(MODE_WAIT, 0, 0, 0, 0, 1, 1));
    add_row(mk_tick(1, 0, MODE_START, 0, {1'b0, BASE_SPEED_RST}, 0, 0), 1,
            mk_res(MODE_WAIT, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(1, 0, MODE_START, 0, 32'h8000_0000, 0, 0), 1,
            mk_res(MODE_WAIT, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(1, 0, MODE_START, 0, {1'b0, BASE_SPEED_RST} + 1, 0, 32'd12345), 1,
            mk_res(MODE_PI, {1'b0, BASE_SPEED_RST}, 1, 1, 0, 0, 0));
    add_row(mk_tick(1, 0, MODE_START, 0, 0, 0, 0), 0, none);
    add_row(mk_tick(1, 0, MODE_START, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0), 0, none);
    add_row(mk_tick(1, 0, MODE_START, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0), 0, none);
    // stopped in PI mode: integrator held
    add_row(mk_tick(0, 0, MODE_START, 32'h7FFF_FFFF, 0, 0, 0), 1,
            mk_res(MODE_PI, 0, 0, 0, 0, 1, 1));
    add_row(mk_tick(1, 0, MODE_START, 0, 0, 0, 0), 0, none);
    add_row(mk_tick(1, 1, MODE_IDLE, 0, 0, 0, 0), 1, mk_res(MODE_IDLE, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(1, 1, 7'd3, 0, 0, 0, 0), 1, mk_res(7'd3, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(1, 1, 7'd5, 0, 0, 0, 0), 1, mk_res(7'd5, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(1, 1, 7'd127, '1, '1, '1, '1), 1, mk_res(7'd127, 0, 0, 0, 0, 0, 0));
    add_row(mk_tick(0, 0, MODE_START, 0, 0, 0, 0), 1, mk_res(7'd127, 0, 0, 0, 0, 1, 1));
    // handoff with the integrator preloaded at the negative extreme
    add_row(mk_tick(1, 1, MODE_WAIT, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000), 1,
            mk_res(MODE_PI, {1'b0, BASE_SPEED_RST}, 1, 1, 0, 0, 0));
    add_row(mk_tick(1, 0, MODE_START, 0, 0, 0, 0), 0, none);
    add_row(mk_tick(1, 1, MODE_PI, 32'd30 << 16, 0, 32'h0001_0000, 32'h7FFF_FFFF), 0, none);
    add_row(mk_tick(1, 1, MODE_START, 0, 0, 0, 0), 1,
            mk_res(MODE_START, START_REF_Q16, 1, 0, 0, 0, 0));
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(in_item_t t, bit typed, out_item_t typed_res);
    out_item_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    p = predict_ctl_step(t);
    due_results.push_back(typed ? typed_res : p);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BASE_SPEED: cfg_base = val[CFG_W-1:0];
      REG_PROP_GAIN:  cfg_kp   = val[CFG_W-1:0];
      REG_INTEG_GAIN: cfg_ki   = val[CFG_W-1:0];
      REG_IQ_LIMIT:   cfg_lim  = val[CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count++;
    end
  endtask

  task automatic take_result(out_item_t a);
    out_item_t e;
    if (due_results.size() == 0) begin
      $error("result item with no tick pending");
      fail_count++;
      return;
    end
    e = due_results.pop_front();
    check_field("mode_now", e.mode_now, a.mode_now);
    check_field("speed_ref_out", $signed(e.speed_ref_out), $signed(a.speed_ref_out));
    check_field("speed_ref_forced", e.speed_ref_forced, a.speed_ref_forced);
    check_field("handoff", e.handoff, a.handoff);
    check_field("iq_ref", $signed(e.iq_ref), $signed(a.iq_ref));
    check_field("iq_ref_valid", e.iq_ref_valid, a.iq_ref_valid);
    check_field("id_ref_clear", e.id_ref_clear, a.id_ref_clear);
  endtask

  // result side
  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) take_result(out_data);
      @(negedge clk);
    end
  end

  initial begin
    int       ph;
    in_item_t t;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BASE_SPEED;
    cfg_data  = '0;
    build_rows();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_tick(rows[i].tick, rows[i].typed, rows[i].res);
    in_valid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (ph)
        0: begin
          write_reg(REG_BASE_SPEED, '0);
          write_reg(REG_PROP_GAIN, '0);
          write_reg(REG_INTEG_GAIN, '0);
          write_reg(REG_IQ_LIMIT, '0);
        end
        1: begin
          write_reg(REG_BASE_SPEED, '1);
          write_reg(REG_PROP_GAIN, '1);
          write_reg(REG_INTEG_GAIN, '1);
          write_reg(REG_IQ_LIMIT, '1);
        end
        NUM_PHASES - 1: begin
          write_reg(REG_BASE_SPEED, $urandom);
          write_reg(REG_PROP_GAIN, $urandom);
          write_reg(REG_INTEG_GAIN, $urandom);
          write_reg(REG_IQ_LIMIT, $urandom);
        end
        default: begin
          write_reg(REG_BASE_SPEED, $urandom_range(0, 2000) << 16);
          write_reg(REG_PROP_GAIN, $urandom_range(0, 32'h0008_0000));
          write_reg(REG_INTEG_GAIN, $urandom_range(0, 32'h0000_8000));
          write_reg(REG_IQ_LIMIT, $urandom_range(0, 32'h0010_0000));
        end
      endcase
      cfg_valid <= 1'b0;
      // long output stall so the block backs up into its input
      if (ph == 4) hold_req = 1'b1;
      repeat (PHASE_TICKS) begin
        t = make_tick();
        send_tick(t, 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("sensorless_speed_pi_controller_top regression: pass");
    end else begin
      $display("sensorless_speed_pi_controller_top regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/sspi_pkg.sv
rtl/sspi_datapath.sv
rtl/sspi_ctrl.sv
rtl/sensorless_speed_pi_controller_top.sv
verif/tb_sensorless_speed_pi_controller_top.sv
